/* rtl/ids_pkg.sv */
// shared types and constants for the indexed deque store
// command and status codes, controller states, fixed field widths
// no dependencies
package ids_pkg;

	localparam int CMD_W        = 3;
	localparam int POS_W        = 9;
	localparam int DATA_W       = 32;
	localparam int STAT_W       = 2;
	localparam int COUNT_W      = 9;
	localparam int DEF_CAPACITY = 256;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_INSERT     = 3'd4,
		CMD_DELETE     = 3'd5,
		CMD_READ       = 3'd6,
		CMD_CLEAR      = 3'd7
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_GRAB,
		S_SHIFT,
		S_DRAIN,
		S_PUT,
		S_RESP
	} state_t;

endpackage

/* rtl/ids_ram.sv */
// entry memory of the indexed deque store: one write port, one read port
// read data registered, valid in the cycle after the read address
// depends on ids_pkg
module ids_ram #(
	parameter int DEPTH  = ids_pkg::DEF_CAPACITY,
	parameter int ADDR_W = $clog2(ids_pkg::DEF_CAPACITY)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [ids_pkg::DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [ids_pkg::DATA_W-1:0] rdata
);
	import ids_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/indexed_deque_store_unit.sv */
// top level of the indexed deque store: command decode, ring pointers,
// shift sequencer and result register around one entry memory
// depends on ids_pkg and ids_ram
//
// usage
// - input channel (in_valid / in_stall) carries one command transaction:
//   command, position and item_value; output channel (out_valid / out_stall)
//   returns exactly one result transaction per command: read_value, status
//   and entry_count (count after the command)
// - one command is worked at a time; in_stall is high from acceptance until
//   its result has been moved into the output register
// - rejected commands and clear go straight to the result register; a push or
//   an insert at an end writes its entry directly, and read, pop and delete at
//   an end fetch the addressed entry first; a middle insert or delete also
//   shifts the entries between the position and the back, one entry per cycle
//   through the single memory read/write port pair
// - a stalled result stays in the output register; the block still takes
//   and works the next command, and waits only when it has a second result
//   ready before the first was taken
// - reset (arst_n low) empties the store and clears front pointer and all
//   handshake state; memory contents are not cleared, and no unwritten entry
//   is ever read
module indexed_deque_store_unit #(
	parameter int CAPACITY = ids_pkg::DEF_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ids_pkg::CMD_W-1:0]   command,
	input  logic [ids_pkg::POS_W-1:0]   position,
	input  logic [ids_pkg::DATA_W-1:0]  item_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ids_pkg::DATA_W-1:0]  read_value,
	output logic [ids_pkg::STAT_W-1:0]  status,
	output logic [ids_pkg::COUNT_W-1:0] entry_count
);
	import ids_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	// physical slot of logical index k, ring wraps at CAPACITY
	function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] k);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return ADDR_W'(sum);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
		return (a == ADDR_W'(CAPACITY - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
		return (a == '0) ? ADDR_W'(CAPACITY - 1) : a - 1'b1;
	endfunction

	// control state
	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  front_q;
	logic [CNT_W-1:0]   count_q;
	logic               mv_s1;
	logic               out_valid_q;

	// working registers of the current command
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   pos_q;
	logic [DATA_W-1:0]  val_q;
	status_t            stat_q;
	logic [DATA_W-1:0]  res_q;
	logic [ADDR_W-1:0]  rd_slot_q;
	logic [CNT_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  put_slot_q;
	logic [ADDR_W-1:0]  mv_dst_s1;

	// output register
	logic [DATA_W-1:0]  read_value_q;
	status_t            status_q;
	logic [COUNT_W-1:0] entry_count_q;

	// memory port
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [DATA_W-1:0]  mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [DATA_W-1:0]  mem_rdata;

	// acceptance decode
	cmd_t               in_cmd;
	logic               in_accept;
	logic [CMD_W-1:0]   cnt_x_unused;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   eff_pos;
	logic               is_full;
	status_t            acc_stat;
	logic               acc_go;

	// command classes of the held command
	logic               cmd_ins;
	logic               cmd_rmv;
	logic               res_load;

	assign in_cmd    = cmd_t'(command);
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cnt_x     = CMP_W'(count_q);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign cnt_x_unused = '0;

	// inserts cover both pushes; removals cover both pops and delete
	assign cmd_ins = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT) ||
		(cmd_q == CMD_INSERT);
	assign cmd_rmv = (cmd_q == CMD_POP_BACK) || (cmd_q == CMD_POP_FRONT) ||
		(cmd_q == CMD_DELETE);

	// in S_RESP, the result register is free or its transaction completes this cycle
	assign res_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// logical position and status of an incoming command
	always_comb begin
		eff_pos  = CMP_W'(position) | CMP_W'(cnt_x_unused);
		acc_stat = ST_DONE;
		case (in_cmd) inside
			CMD_PUSH_BACK: eff_pos = cnt_x;
			CMD_POP_BACK: eff_pos = cnt_x - 1'b1;
			CMD_PUSH_FRONT, CMD_POP_FRONT: eff_pos = '0;
			default: eff_pos = CMP_W'(position);
		endcase
		case (in_cmd) inside
			CMD_PUSH_BACK, CMD_INSERT: begin
				// range check ranks above the full check
				if (eff_pos > cnt_x) begin
					acc_stat = ST_RANGE;
				end else if (is_full) begin
					acc_stat = ST_FULL;
				end
			end
			CMD_PUSH_FRONT: begin
				if (is_full) begin
					acc_stat = ST_FULL;
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT, CMD_DELETE, CMD_READ: begin
				if (count_q == '0 || eff_pos >= cnt_x) begin
					acc_stat = ST_RANGE;
				end
			end
			default: acc_stat = ST_DONE;
		endcase
		acc_go = (acc_stat == ST_DONE) && (in_cmd != CMD_CLEAR);
	end

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		// a move in flight writes the entry read in the cycle before
		mem_we    = mv_s1;
		mem_waddr = mv_dst_s1;
		mem_wdata = mem_rdata;
		mem_raddr = rd_slot_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = acc_go ? S_EXEC : S_RESP;
				end
			end
			S_EXEC: begin
				if (cmd_ins) begin
					if (pos_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = slot_dec(front_q);
						mem_wdata = val_q;
						state_d   = S_RESP;
					end else if (pos_q == count_q) begin
						mem_we    = 1'b1;
						mem_waddr = slot_of(front_q, count_q);
						mem_wdata = val_q;
						state_d   = S_RESP;
					end else begin
						state_d = S_SHIFT;
					end
				end else begin
					// read, pop or delete: fetch the addressed entry
					mem_raddr = slot_of(front_q, pos_q);
					state_d   = S_GRAB;
				end
			end
			S_GRAB: begin
				if (!cmd_rmv || pos_q == '0 || pos_q == count_q - 1'b1) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (rem_q == CNT_W'(1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = cmd_ins ? S_PUT : S_RESP;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = put_slot_q;
				mem_wdata = val_q;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring pointers, move pipeline flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			mv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mv_s1 <= (state_q == S_SHIFT);
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept && in_cmd == CMD_CLEAR) begin
						front_q <= '0;
						count_q <= '0;
					end
				end
				S_EXEC: begin
					if (cmd_ins && pos_q == '0) begin
						front_q <= slot_dec(front_q);
						count_q <= count_q + 1'b1;
					end else if (cmd_ins && pos_q == count_q) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_GRAB: begin
					if (cmd_rmv && pos_q == '0) begin
						front_q <= slot_inc(front_q);
						count_q <= count_q - 1'b1;
					end else if (cmd_rmv && pos_q == count_q - 1'b1) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_DRAIN: begin
					if (!cmd_ins) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// command working registers and shift sequencer
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q  <= in_cmd;
			pos_q  <= CNT_W'(eff_pos);
			val_q  <= item_value;
			stat_q <= acc_stat;
			res_q  <= '0;
		end
		// insert moves entries toward the back, starting at the last one;
		// delete moves them toward the front, starting after the hole
		mv_dst_s1 <= cmd_ins ? slot_inc(rd_slot_q) : slot_dec(rd_slot_q);
		case (state_q)
			S_EXEC: begin
				rd_slot_q  <= slot_of(front_q, count_q - 1'b1);
				rem_q      <= count_q - pos_q;
				put_slot_q <= slot_of(front_q, pos_q);
			end
			S_GRAB: begin
				res_q     <= mem_rdata;
				rd_slot_q <= slot_of(front_q, pos_q + 1'b1);
				rem_q     <= count_q - pos_q - 1'b1;
			end
			S_SHIFT: begin
				rd_slot_q <= cmd_ins ? slot_dec(rd_slot_q) : slot_inc(rd_slot_q);
				rem_q     <= rem_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			read_value_q  <= res_q;
			status_q      <= stat_q;
			entry_count_q <= COUNT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	ids_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* sim/indexed_deque_store_unit_test.sv */
// testbench for the indexed deque store: directed and random command streams
// checked against a behavioral deque model kept alongside the block
// depends on ids_pkg and indexed_deque_store_unit
`timescale 1ns / 1ps

module indexed_deque_store_unit_test;
	import ids_pkg::*;

	localparam int          DEPTH       = DEF_CAPACITY;
	// cycles left after the last result so a late extra one can still show up
	localparam int          SETTLE      = 300;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          REPORT_MAX  = 10;

	typedef struct packed {
		logic [DATA_W-1:0]  value;
		status_t            stat;
		logic [COUNT_W-1:0] count;
	} result_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command    = '0;
	logic [POS_W-1:0]    position   = '0;
	logic [DATA_W-1:0]   item_value = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [DATA_W-1:0]   read_value;
	logic [STAT_W-1:0]   status;
	logic [COUNT_W-1:0]  entry_count;

	// deque model state: ring memory, front slot and fill level
	logic [DATA_W-1:0]   model_mem [DEPTH];
	int unsigned         model_front = 0;
	int unsigned         model_count = 0;

	// results still owed by the block, oldest first
	result_t             awaited_results [$];

	// idle percentages for the sender and the receiver
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_idle_pct = 0;

	int unsigned         fail_count  = 0;
	int unsigned         cycle_count = 0;

	indexed_deque_store_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.position    (position),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs or drops a result
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver back-pressure, independent of anything the block does
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic int unsigned ring_slot(int unsigned k);
		return (model_front + k) % DEPTH;
	endfunction

	// apply one command to the deque model and return the result it owes
	function automatic result_t predict_deque_result(cmd_t cmd, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		result_t     res;
		int unsigned idx;
		int unsigned k;
		res.value = '0;
		res.stat  = ST_DONE;
		idx       = 32'(pos);
		case (cmd)
			CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
				// push back is an insert at the end, push front an insert at 0
				if (cmd == CMD_PUSH_BACK)
					idx = model_count;
				else if (cmd == CMD_PUSH_FRONT)
					idx = 0;
				// range check wins over the full check
				if (idx > model_count) begin
					res.stat = ST_RANGE;
				end else if (model_count >= DEPTH) begin
					res.stat = ST_FULL;
				end else if (idx == 0) begin
					model_front = (model_front + DEPTH - 1) % DEPTH;
					model_mem[model_front] = val;
					model_count++;
				end else begin
					// open a hole at idx by moving the tail back one slot
					for (k = model_count; k > idx; k--)
						model_mem[ring_slot(k)] = model_mem[ring_slot(k - 1)];
					model_mem[ring_slot(idx)] = val;
					model_count++;
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT, CMD_DELETE: begin
				if (model_count == 0 || (cmd == CMD_DELETE && idx >= model_count)) begin
					res.stat = ST_RANGE;
				end else begin
					if (cmd == CMD_POP_BACK)
						idx = model_count - 1;
					else if (cmd == CMD_POP_FRONT)
						idx = 0;
					if (idx == 0) begin
						res.value   = model_mem[model_front];
						model_front = (model_front + 1) % DEPTH;
					end else begin
						// close the hole by pulling the tail forward
						res.value = model_mem[ring_slot(idx)];
						for (k = idx; k + 1 < model_count; k++)
							model_mem[ring_slot(k)] = model_mem[ring_slot(k + 1)];
					end
					model_count--;
				end
			end
			CMD_READ: begin
				if (idx >= model_count)
					res.stat = ST_RANGE;
				else
					res.value = model_mem[ring_slot(idx)];
			end
			default: begin
				// clear
				model_count = 0;
				model_front = 0;
			end
		endcase
		res.count = model_count[COUNT_W-1:0];
		return res;
	endfunction

	task automatic report_failure(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("mismatch at %0t on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// compare each result transaction against the oldest pending prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_failure("unexpected result, read_value", '0, read_value);
			end else begin
				want = awaited_results.pop_front();
				if (read_value !== want.value)
					report_failure("read_value", want.value, read_value);
				if (status !== want.stat)
					report_failure("status", DATA_W'(want.stat), DATA_W'(status));
				if (entry_count !== want.count)
					report_failure("entry_count", DATA_W'(want.count), DATA_W'(entry_count));
			end
		end
	end

	// send one command transaction, with a random idle gap in front of it
	task automatic issue_command(cmd_t cmd, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		position   <= pos;
		item_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// accepted at this edge, so the model advances now
		awaited_results.push_back(predict_deque_result(cmd, pos, val));
	endtask

	// hold the sender off until every owed result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// commands on an empty store: all rejected as out of range
	task automatic test_empty_store();
		issue_command(CMD_POP_BACK, 9'd0, 32'h0);
		issue_command(CMD_POP_FRONT, 9'd511, 32'hFFFF_FFFF);
		issue_command(CMD_DELETE, 9'd0, 32'h0);
		issue_command(CMD_READ, 9'd0, 32'h0);
		issue_command(CMD_INSERT, 9'd1, 32'h1111_1111);
		wait_for_results();
	endtask

	// end pushes and pops, inserts at front, end and middle, deletes, reads, clear
	task automatic test_end_and_index_ops();
		issue_command(CMD_PUSH_BACK, 9'd0, 32'h0);
		issue_command(CMD_PUSH_FRONT, 9'd511, 32'hFFFF_FFFF);
		issue_command(CMD_INSERT, 9'd0, 32'hA5A5_A5A5);
		issue_command(CMD_INSERT, 9'd3, 32'h5A5A_5A5A);
		issue_command(CMD_INSERT, 9'd2, 32'h1234_5678);
		issue_command(CMD_INSERT, 9'd6, 32'hDEAD_BEEF);
		issue_command(CMD_READ, 9'd0, 32'h0);
		issue_command(CMD_READ, 9'd4, 32'h0);
		issue_command(CMD_READ, 9'd5, 32'h0);
		issue_command(CMD_READ, 9'd511, 32'hFFFF_FFFF);
		issue_command(CMD_DELETE, 9'd2, 32'h0);
		issue_command(CMD_DELETE, 9'd0, 32'h0);
		issue_command(CMD_DELETE, 9'd2, 32'h0);
		issue_command(CMD_POP_BACK, 9'd0, 32'h0);
		issue_command(CMD_POP_FRONT, 9'd0, 32'h0);
		issue_command(CMD_PUSH_BACK, 9'd511, 32'hFFFF_FFFF);
		issue_command(CMD_PUSH_BACK, 9'd0, 32'h0000_0001);
		issue_command(CMD_CLEAR, 9'd511, 32'hFFFF_FFFF);
		issue_command(CMD_READ, 9'd0, 32'h0);
		issue_command(CMD_PUSH_FRONT, 9'd0, 32'h8000_0000);
		wait_for_results();
	endtask

	// fill to capacity, hit the full and range checks, long shifts at full size
	task automatic test_full_store();
		int unsigned k;
		issue_command(CMD_CLEAR, 9'd0, 32'h0);
		// mixing both ends makes the front slot wrap around the ring
		for (k = 0; k < DEPTH; k++)
			issue_command(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
				POS_W'($urandom_range(511)), $urandom);
		issue_command(CMD_PUSH_BACK, 9'd0, 32'hFFFF_FFFF);
		issue_command(CMD_PUSH_FRONT, 9'd0, 32'hFFFF_FFFF);
		issue_command(CMD_INSERT, 9'd100, 32'hFFFF_FFFF);
		issue_command(CMD_INSERT, 9'd256, 32'hFFFF_FFFF);
		// past the end while full: range status, not full status
		issue_command(CMD_INSERT, 9'd257, 32'hFFFF_FFFF);
		issue_command(CMD_INSERT, 9'd511, 32'hFFFF_FFFF);
		issue_command(CMD_READ, 9'd255, 32'h0);
		issue_command(CMD_READ, 9'd256, 32'h0);
		issue_command(CMD_DELETE, 9'd128, 32'h0);
		issue_command(CMD_INSERT, 9'd1, $urandom);
		issue_command(CMD_DELETE, 9'd1, 32'h0);
		issue_command(CMD_INSERT, 9'd255, $urandom);
		issue_command(CMD_DELETE, 9'd255, 32'h0);
		issue_command(CMD_POP_FRONT, 9'd0, 32'h0);
		issue_command(CMD_POP_BACK, 9'd0, 32'h0);
		issue_command(CMD_READ, 9'd0, 32'h0);
		wait_for_results();
		issue_command(CMD_CLEAR, 9'd0, 32'h0);
	endtask

	// random command mix; the fill level hovers around soft_cap
	task automatic test_random_mix(int unsigned n_items, int unsigned soft_cap);
		cmd_t              cmd;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		int unsigned       pick;
		int unsigned       span;
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				cmd = CMD_CLEAR;
			end else if (pick < 22) begin
				cmd = CMD_READ;
			end else if ($urandom_range(99) < ((model_count < soft_cap) ? 55 : 25)) begin
				case ($urandom_range(2))
					0: cmd = CMD_PUSH_BACK;
					1: cmd = CMD_PUSH_FRONT;
					default: cmd = CMD_INSERT;
				endcase
			end else begin
				case ($urandom_range(2))
					0: cmd = CMD_POP_BACK;
					1: cmd = CMD_POP_FRONT;
					default: cmd = CMD_DELETE;
				endcase
			end
			// number of legal indexes for this command
			span = (cmd == CMD_INSERT) ? model_count + 1 : model_count;
			if (cmd == CMD_INSERT || cmd == CMD_DELETE || cmd == CMD_READ) begin
				pick = $urandom_range(9);
				if (span == 0 || pick == 0)
					pos = POS_W'($urandom_range(511, span));
				else if (pick < 3)
					pos = '0;
				else if (pick < 5)
					pos = POS_W'(span - 1);
				else
					pos = POS_W'($urandom_range(span - 1));
			end else begin
				// index is ignored here, so any bit pattern goes
				pos = POS_W'($urandom_range(511));
			end
			pick = $urandom_range(19);
			if (pick == 0)
				val = 32'h0;
			else if (pick == 1)
				val = 32'hFFFF_FFFF;
			else
				val = $urandom;
			issue_command(cmd, pos, val);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver stalling often
		send_idle_pct = 12;
		recv_idle_pct = 58;
		test_empty_store();
		test_end_and_index_ops();
		test_full_store();
		test_random_mix(110, 32);
		wait_for_results();

		// sender idling often, receiver mostly ready
		send_idle_pct = 58;
		recv_idle_pct = 12;
		test_random_mix(110, 48);
		wait_for_results();

		// back to back, no sender gaps and no receiver stalls
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(110, 24);
		wait_for_results();

		// any stray extra result would show up in this window
		repeat (SETTLE) @(posedge clk);
		fail_count += unsigned'(awaited_results.size());
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
